[sv/mpts_pkg.sv]
`timescale 1ns / 1ps
package mpts_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int SLOT_W        = 4;
    localparam logic [15:0] RESET_QUANTUM = 16'd10;

    typedef enum logic [1:0] {
        POL_RR   = 2'd0,
        POL_FCFS = 2'd1,
        POL_SJF  = 2'd2,
        POL_PRIO = 2'd3
    } policy_t;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [0:0]  kind;
        logic [3:0]  slot;
        logic        present;
        logic        runnable;
        logic [7:0]  prio;
        logic [15:0] quantum;
        logic [31:0] arrival;
        logic [15:0] burst;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  current_task;
        logic        switched;
        logic [31:0] elapsed_ticks;
        logic [31:0] current_wait;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic do_write;   // write slot
        logic scan_start; // clear scan state, count tick
        logic scan_step;  // visit one slot
        logic decide;     // apply policy
        logic finish;     // build result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic scan_last;
        logic any_present;
    } dp_sts_t;

endpackage

[sv/mpts_if.sv]
`timescale 1ns / 1ps
interface mpts_in_if;
    logic               valid;
    logic               ready;
    mpts_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mpts_out_if;
    logic                valid;
    logic                ready;
    mpts_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/multi_policy_task_scheduler_unit.sv]
`timescale 1ns / 1ps
// Multi-policy task scheduler.
// Input channel in: one transaction is a tick (kind 0) or a slot write
// (kind 1). Output channel out: one result transaction per input.
// Configuration: policy_we/policy_wdata set the policy (round robin, first
// come first served, shortest job first, priority); write only while idle.
// One item at a time: a write, or a tick with no slot present, goes from
// the load state straight to the finish and out states; a tick first walks
// the slot table one slot a cycle, updating waits and picking a candidate,
// then decides and builds the result.
// in.ready is high only while no item is held, so the next item is taken
// the cycle after its result is taken.
// Reset: slot 0 present and runnable with quantum 10, running slot 0,
// tick count zero, policy round robin.
// Stalls: the result stays on out until out.ready; no input is accepted
// meanwhile.
module multi_policy_task_scheduler_unit #(
    parameter int NUM_SLOTS = mpts_pkg::DEF_NUM_SLOTS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       policy_we,
    input  logic [1:0] policy_wdata,
    mpts_in_if.sink    in,
    mpts_out_if.source out
);
    import mpts_pkg::*;

    logic [1:0] policy_reg;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    // policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_RR;
        else if (policy_we)
            policy_reg <= policy_wdata;
    end

    mpts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mpts_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .policy (policy_reg),
        .item   (in.data),
        .cmd    (cmd),
        .sts    (sts),
        .result (out.data)
    );

endmodule

[sv/mpts_ctrl.sv]
`timescale 1ns / 1ps
module mpts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mpts_pkg::dp_cmd_t cmd,
    input  mpts_pkg::dp_sts_t sts
);
    import mpts_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.is_write)
                begin
                    cmd.do_write = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (!sts.any_present)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/mpts_dp.sv]
`timescale 1ns / 1ps
module mpts_dp #(
    parameter int NUM_SLOTS = mpts_pkg::DEF_NUM_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          policy,
    input  mpts_pkg::in_item_t  item,
    input  mpts_pkg::dp_cmd_t   cmd,
    output mpts_pkg::dp_sts_t   sts,
    output mpts_pkg::out_item_t result
);
    import mpts_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

    // slot table, small and walked one entry a cycle
    logic [NUM_SLOTS-1:0] present_reg, runnable_reg;
    logic [7:0]  prio_reg    [NUM_SLOTS];
    logic [15:0] quantum_reg [NUM_SLOTS];
    logic [31:0] arrival_reg [NUM_SLOTS];
    logic [15:0] burst_reg   [NUM_SLOTS];
    logic [31:0] runtime_reg [NUM_SLOTS];
    logic [31:0] waited_reg  [NUM_SLOTS];

    logic [IW-1:0] running_reg, before_reg, idx_reg, best_reg, next_reg;
    logic [31:0]   tick_reg;
    in_item_t      item_reg;
    logic          found_reg, next_found_reg;
    out_item_t     result_reg;

    logic          elig, better, wr_ok;
    logic [IW-1:0] widx;

    assign widx  = IW'(item_reg.slot);
    assign wr_ok = ({{(32-SLOT_W){1'b0}}, item_reg.slot} < 32'(NUM_SLOTS));

    assign sts.is_write    = (item_reg.kind == KIND_WRITE);
    assign sts.scan_last   = (idx_reg == LAST);
    assign sts.any_present = |present_reg;
    assign result          = result_reg;

    // candidate compare for the slot under scan
    always_comb
    begin
        elig   = present_reg[idx_reg] && runnable_reg[idx_reg];
        better = 1'b0;
        unique case (policy)
            POL_FCFS: better = elig && (!found_reg ||
                              arrival_reg[idx_reg] < arrival_reg[best_reg]);
            POL_SJF:  better = elig && burst_reg[idx_reg] != 16'd0 && (!found_reg ||
                              burst_reg[idx_reg] < burst_reg[best_reg]);
            POL_PRIO: better = elig && prio_reg[idx_reg] != 8'd0 && (!found_reg ||
                              prio_reg[idx_reg] > prio_reg[best_reg]);
            default:  better = 1'b0;
        endcase
    end

    // control-visible state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            runnable_reg <= {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            running_reg  <= '0;
            tick_reg     <= '0;
        end
        else
        begin
            if (cmd.do_write && wr_ok)
            begin
                present_reg[widx]  <= item_reg.present;
                runnable_reg[widx] <= item_reg.runnable;
            end
            if (cmd.scan_start)
                tick_reg <= tick_reg + 32'd1;
            if (cmd.decide)
            begin
                priority if (policy == POL_RR)
                begin
                    if (quantum_reg[running_reg] != 16'd0 &&
                        runtime_reg[running_reg] >= {16'd0, quantum_reg[running_reg]})
                        running_reg <= next_found_reg ? next_reg : running_reg;
                end
                else if (found_reg && best_reg != running_reg)
                begin
                    priority if (policy == POL_SJF && burst_reg[running_reg] != 16'd0 &&
                        runtime_reg[running_reg] < {16'd0, burst_reg[running_reg]})
                        running_reg <= running_reg;
                    else if (policy == POL_PRIO &&
                             prio_reg[best_reg] <= prio_reg[running_reg])
                        running_reg <= running_reg;
                    else
                        running_reg <= best_reg;
                end
            end
        end
    end

    // slot payload and run/wait counters; reset values loaded here as well
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                prio_reg[i]    <= '0;
                quantum_reg[i] <= (i == 0) ? RESET_QUANTUM : 16'd0;
                arrival_reg[i] <= '0;
                burst_reg[i]   <= '0;
                runtime_reg[i] <= '0;
                waited_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.do_write && wr_ok)
            begin
                prio_reg[widx]    <= item_reg.prio;
                quantum_reg[widx] <= item_reg.quantum;
                arrival_reg[widx] <= item_reg.arrival;
                burst_reg[widx]   <= item_reg.burst;
                runtime_reg[widx] <= '0;
                waited_reg[widx]  <= '0;
            end
            if (cmd.scan_start)
                runtime_reg[running_reg] <= runtime_reg[running_reg] + 32'd1;
            if (cmd.scan_step && idx_reg != running_reg && elig)
                waited_reg[idx_reg] <= waited_reg[idx_reg] + 32'd1;
            if (cmd.decide && policy == POL_RR && quantum_reg[running_reg] != 16'd0 &&
                runtime_reg[running_reg] >= {16'd0, quantum_reg[running_reg]})
                runtime_reg[running_reg] <= '0;
        end
    end

    // item capture, scan bookkeeping, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= item;
            before_reg <= running_reg;
        end
        if (cmd.scan_start)
        begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            next_found_reg <= 1'b0;
            next_reg       <= running_reg;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IW'(1);
            if (better)
            begin
                best_reg  <= idx_reg;
                found_reg <= 1'b1;
            end
            // next present slot in ring order after the running one
            if (present_reg[idx_reg])
            begin
                if (idx_reg > running_reg && (!next_found_reg || next_reg <= running_reg))
                begin
                    next_reg       <= idx_reg;
                    next_found_reg <= 1'b1;
                end
                else if (idx_reg <= running_reg && !next_found_reg)
                begin
                    next_reg       <= idx_reg;
                    next_found_reg <= 1'b1;
                end
            end
        end
        if (cmd.finish)
        begin
            result_reg.current_task  <= SLOT_W'(running_reg);
            result_reg.switched      <= (running_reg != before_reg);
            result_reg.elapsed_ticks <= tick_reg;
            result_reg.current_wait  <= waited_reg[running_reg];
        end
    end

endmodule

[sv/mpts_checker.sv]
`timescale 1ns / 1ps
module mpts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] elapsed_ticks
);
    // no input while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready with result pending");

    // a result follows an accepted transaction, not straight away
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(elapsed_ticks)))
        else $error("result dropped");

    // after a result is taken the block is ready again
    a_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("not ready after result");
endmodule

bind multi_policy_task_scheduler_unit mpts_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .elapsed_ticks (out.data.elapsed_ticks)
);
